// ----- sv/consistent_hash_server_ring_macros.svh -----
// Assertion macros for the consistent hash server ring checker
`ifndef CONSISTENT_HASH_SERVER_RING_MACROS_SVH
`define CONSISTENT_HASH_SERVER_RING_MACROS_SVH

// assert that a property holds at every clock edge out of reset
`define CHSR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// assert that an antecedent in one cycle implies a consequent in the next
`define CHSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/chsr_pkg.sv -----
// Types and constants shared by the consistent hash server ring
package chsr_pkg;

    localparam logic [31:0] MM_M = 32'h5bd1e995;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  server_id;
        logic [31:0] server_ip;
        logic [15:0] server_port;
        logic [31:0] key_hash;
    } in_word_t;

    typedef struct packed {
        logic [3:0] chosen_server;
        logic [1:0] status;
    } out_word_t;

    // operations of the shared hash unit
    typedef enum logic [2:0] {
        HOP_LOAD,
        HOP_MUL_K,
        HOP_SHR24_K,
        HOP_MUL_H,
        HOP_XOR_K,
        HOP_FIN13,
        HOP_FIN15,
        HOP_XOR_HALF
    } hop_t;

    typedef struct packed {
        hop_t        op;
        logic [31:0] operand;
    } hash_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_H_START,
        ST_H_K1,
        ST_H_K2,
        ST_H_K3,
        ST_H_H,
        ST_H_XK,
        ST_H_F13,
        ST_H_F15A,
        ST_H_F15B,
        ST_B_START,
        ST_B_MUL,
        ST_B_F13,
        ST_B_F15A,
        ST_B_F15B,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_LK_RD,
        ST_LK_CMP,
        ST_LK_OWN,
        ST_LK_DONE,
        ST_OUT
    } state_t;

endpackage

// ----- sv/chsr_hash_unit.sv -----
// Shared MurmurHash2 step unit: one multiply, xor or shift per cycle while en is high
module chsr_hash_unit
    import chsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  hash_cmd_t   cmd,
    output logic [31:0] h
);

    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;

    always_comb
    begin
        h_next = h_reg;
        k_next = k_reg;
        case (cmd.op)
            HOP_LOAD:     begin h_next = cmd.operand; end
            HOP_MUL_K:    begin k_next = k_reg * MM_M; end
            HOP_SHR24_K:  begin k_next = k_reg ^ (k_reg >> 24); end
            HOP_MUL_H:    begin h_next = h_reg * MM_M; end
            HOP_XOR_K:    begin h_next = h_reg ^ k_reg; end
            HOP_FIN13:    begin h_next = h_reg ^ (h_reg >> 13); end
            HOP_FIN15:    begin h_next = h_reg ^ (h_reg >> 15); end
            HOP_XOR_HALF: begin k_next = cmd.operand; end
            default:      begin h_next = h_reg; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= '0;
            k_reg <= '0;
        end
        else if (en)
        begin
            h_reg <= h_next;
            k_reg <= k_next;
        end
    end

    assign h = h_reg;

endmodule

// ----- sv/chsr_ring_mem.sv -----
// Ring point memory: one write and one registered read port
module chsr_ring_mem
    import chsr_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [35:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [35:0]   rdata
);

    logic [35:0] mem [DEPTH];
    logic [35:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/consistent_hash_server_ring.sv -----
// Top level of the consistent hash server ring
// Usage:
//   Input channel in/in_valid/in_stall carries one word per item: clear, add or lookup.
//   Output channel out/out_valid/out_stall returns exactly one word per item.
//   in_stall is high whenever an item is in work or its result waits to be taken.
//   Clear and a full-ring add go straight to the result word.
//   An add runs the shared hash unit for the base hash, then for each of BUCKETS
//   points hashes the point, scans the ring for its slot and shifts the points
//   above it up by one through the ring memory, with count growing by one per
//   placed point.
//   A lookup binary-searches the ring, one memory read per probe, then reads the owner.
//   One item at a time: a new item is taken only once the last result has been taken.
//   Reset empties the ring (count zero) and drops any word in flight; the memory
//   itself is not cleared, since only points below the count are ever read.
//   While out_stall is high the result word holds and no new item is taken.
module consistent_hash_server_ring
    import chsr_pkg::*;
#(
    parameter int BUCKETS     = 16,
    parameter int MAX_SERVERS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  in,
    input  logic      in_valid,
    output logic      in_stall,
    output out_word_t out,
    output logic      out_valid,
    input  logic      out_stall
);

    localparam int DEPTH = BUCKETS * MAX_SERVERS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    state_t      state_reg, state_next;
    in_word_t    item_reg, item_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [BW-1:0] bucket_reg, bucket_next;
    logic        stage_reg, stage_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] point_reg, point_next;
    out_word_t   out_reg, out_next;

    hash_cmd_t   cmd;
    logic        hen;
    logic [31:0] hh;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [35:0]   wdata, rdata;
    logic [CW-1:0] mid;

    chsr_hash_unit u_hash (
        .clk (clk),
        .rst_n (rst_n),
        .en  (hen),
        .cmd (cmd),
        .h   (hh)
    );

    chsr_ring_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        bucket_reg <= bucket_next;
        stage_reg  <= stage_next;
        base_reg   <= base_next;
        point_reg  <= point_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        bucket_next = bucket_reg;
        stage_next  = stage_reg;
        base_next   = base_reg;
        point_next  = point_reg;
        out_next    = out_reg;
        cmd.op      = HOP_LOAD;
        cmd.operand = '0;
        hen         = 1'b0;
        we          = 1'b0;
        waddr       = pos_reg[AW-1:0];
        wdata       = {point_reg, item_reg.server_id};
        raddr       = idx_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in;
                    out_next  = '{chosen_server: 4'd0, status: STATUS_OK};
                    case (func_t'(in.func))
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_OUT;
                        end
                        FUNC_ADD:
                        begin
                            if (32'(count_reg) + 32'(BUCKETS) > 32'(DEPTH))
                            begin
                                out_next.status = STATUS_FULL;
                                state_next      = ST_OUT;
                            end
                            else
                            begin
                                stage_next = 1'b0;
                                state_next = ST_H_START;
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status = STATUS_EMPTY;
                                state_next      = ST_OUT;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                state_next = ST_LK_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            // four-byte hash: h = seed ^ 4 loaded, k = word loaded in turn
            ST_H_START:
            begin
                hen         = 1'b1;
                cmd.op      = HOP_XOR_HALF;
                cmd.operand = stage_reg ? 32'(item_reg.server_port) : item_reg.server_ip;
                state_next  = ST_H_K1;
            end
            ST_H_K1:
            begin
                hen         = 1'b1;
                cmd.op      = HOP_LOAD;
                cmd.operand = (stage_reg ? base_reg : 32'd0) ^ 32'd4;
                state_next  = ST_H_K2;
            end
            ST_H_K2:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_MUL_K;
                state_next = ST_H_K3;
            end
            ST_H_K3:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_SHR24_K;
                state_next = ST_H_H;
            end
            ST_H_H:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_MUL_K;
                state_next = ST_H_XK;
            end
            ST_H_XK:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_MUL_H;
                state_next = ST_H_F13;
            end
            ST_H_F13:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_XOR_K;
                state_next = ST_H_F15A;
            end
            ST_H_F15A:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_FIN13;
                state_next = ST_H_F15B;
            end
            ST_H_F15B:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_MUL_H;
                state_next = ST_B_F13;
            end
            // finish the four-byte hash: h ^= h >> 15
            ST_B_F13:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_FIN15;
                state_next = ST_B_MUL;
            end
            ST_B_MUL:
            begin
                base_next = hh;
                if (stage_reg)
                begin
                    bucket_next = '0;
                    state_next  = ST_B_START;
                end
                else
                begin
                    stage_next = 1'b1;
                    state_next = ST_H_START;
                end
            end
            ST_B_START:
            begin
                hen         = 1'b1;
                cmd.op      = HOP_LOAD;
                cmd.operand = base_reg ^ 32'd2 ^ 32'(bucket_reg);
                state_next  = ST_B_F15A;
            end
            ST_B_F15A:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_MUL_H;
                state_next = ST_B_F15B;
            end
            ST_B_F15B:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_FIN13;
                state_next = ST_LK_DONE;
            end
            ST_LK_DONE:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_MUL_H;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                hen        = 1'b1;
                cmd.op     = HOP_FIN15;
                pos_next   = '0;
                idx_next   = '0;
                state_next = ST_SCAN_RD;
            end
            // find first slot whose hash exceeds the new point
            ST_SCAN_RD:
            begin
                point_next = hh;
                if (pos_reg >= count_reg)
                begin
                    idx_next   = count_reg;
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    raddr      = pos_reg[AW-1:0];
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (rdata[35:4] <= point_reg)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    idx_next   = count_reg;
                    state_next = ST_SHIFT_RD;
                end
            end
            // move entries up by one from the top down to pos
            ST_SHIFT_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    raddr      = AW'(idx_reg - 1'b1);
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = pos_reg[AW-1:0];
                    wdata      = {point_reg, item_reg.server_id};
                    count_next = count_reg + 1'b1;
                    if (bucket_reg == BW'(BUCKETS - 1))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        bucket_next = bucket_reg + 1'b1;
                        state_next  = ST_B_START;
                    end
                end
            end
            ST_SHIFT_WR:
            begin
                we         = 1'b1;
                waddr      = idx_reg[AW-1:0];
                wdata      = rdata;
                idx_next   = idx_reg - 1'b1;
                state_next = ST_SHIFT_RD;
            end
            // binary search for first hash strictly above the key
            ST_LK_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    raddr      = mid[AW-1:0];
                    idx_next   = mid;
                    state_next = ST_LK_CMP;
                end
                else
                begin
                    raddr      = (lo_reg >= count_reg) ? '0 : lo_reg[AW-1:0];
                    state_next = ST_LK_OWN;
                end
            end
            ST_LK_CMP:
            begin
                if (item_reg.key_hash < rdata[35:4])
                begin
                    hi_next = idx_reg;
                end
                else
                begin
                    lo_next = idx_reg + 1'b1;
                end
                state_next = ST_LK_RD;
            end
            ST_LK_OWN:
            begin
                out_next.chosen_server = rdata[3:0];
                state_next             = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out       = out_reg;

endmodule

// ----- sv/chsr_checker.sv -----
// Port-level checker for the consistent hash server ring, bound to the top level
`include "consistent_hash_server_ring_macros.svh"
module chsr_checker
    import chsr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input in_word_t  in,
    input logic      in_valid,
    input logic      in_stall,
    input out_word_t out,
    input logic      out_valid,
    input logic      out_stall
);

    `CHSR_ASSERT(a_no_take_while_busy, clk, rst_n, !(out_valid && !in_stall), "input open with result pending")
    `CHSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out), "stalled word changed")
    `CHSR_ASSERT(a_status_code, clk, rst_n, !out_valid || out.status != 2'd3, "bad status code")
    `CHSR_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall, "input not closed after accept")

endmodule

bind consistent_hash_server_ring chsr_checker u_chsr_checker (.*);

// ----- bench/testbench.sv -----
// Self-checking bench for the consistent hash server ring: directed and random words
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import chsr_pkg::*;

    localparam int BUCKETS     = 16;
    localparam int MAX_SERVERS = 16;
    localparam int DEPTH       = BUCKETS * MAX_SERVERS;
    localparam int STALL_LIMIT = 200000;

    class ring_scoreboard;
        bit [31:0]   point_hash [DEPTH];
        bit [3:0]    point_owner [DEPTH];
        int unsigned point_total;
        out_word_t   expected_q [$];
        int          errors;

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function bit [31:0] fold(bit [31:0] h);
            h = h ^ (h >> 13);
            h = h * MM_M;
            h = h ^ (h >> 15);
            return h;
        endfunction

        function bit [31:0] murmur_word(bit [31:0] word, bit [31:0] seed);
            bit [31:0] h;
            bit [31:0] k;
            h = seed ^ 32'd4;
            k = word * MM_M;
            k = k ^ (k >> 24);
            k = k * MM_M;
            h = h * MM_M;
            h = h ^ k;
            return fold(h);
        endfunction

        function bit [31:0] murmur_half(bit [15:0] half, bit [31:0] seed);
            bit [31:0] h;
            h = seed ^ 32'd2;
            h = h ^ {16'd0, half[15:8], 8'd0};
            h = h ^ {24'd0, half[7:0]};
            h = h * MM_M;
            return fold(h);
        endfunction

        function void place(bit [31:0] hv, bit [3:0] owner);
            int unsigned pos;
            pos = 0;
            while (pos < point_total && point_hash[pos] <= hv)
                pos++;
            for (int unsigned i = point_total; i > pos; i--)
            begin
                point_hash[i]  = point_hash[i-1];
                point_owner[i] = point_owner[i-1];
            end
            point_hash[pos]  = hv;
            point_owner[pos] = owner;
            point_total++;
        endfunction

        function void note(in_word_t w);
            out_word_t   r;
            bit [31:0]   base;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            r = '0;
            r.status = STATUS_OK;
            case (func_t'(w.func))
                FUNC_CLEAR: point_total = 0;
                FUNC_ADD:
                begin
                    if (point_total + BUCKETS > DEPTH)
                        r.status = STATUS_FULL;
                    else
                    begin
                        base = murmur_word({16'd0, w.server_port},
                                           murmur_word(w.server_ip, 32'd0));
                        for (int b = 0; b < BUCKETS; b++)
                            place(murmur_half(b[15:0], base), w.server_id);
                    end
                end
                FUNC_LOOKUP:
                begin
                    if (point_total == 0)
                        r.status = STATUS_EMPTY;
                    else
                    begin
                        lo = 0;
                        hi = point_total;
                        while (lo < hi)
                        begin
                            mid = lo + (hi - lo) / 2;
                            if (w.key_hash < point_hash[mid])
                                hi = mid;
                            else
                                lo = mid + 1;
                        end
                        if (lo >= point_total)
                            lo = 0;
                        r.chosen_server = point_owner[lo];
                    end
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        task check(out_word_t got);
            out_word_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.chosen_server !== want.chosen_server)
                report($sformatf("chosen_server %0d, want %0d",
                                 got.chosen_server, want.chosen_server));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    in_word_t  in;
    logic      in_valid;
    logic      in_stall;
    out_word_t out;
    logic      out_valid;
    logic      out_stall;

    ring_scoreboard sb;
    bit  quiet;
    int  idle_cycles;

    consistent_hash_server_ring #(.BUCKETS(BUCKETS), .MAX_SERVERS(MAX_SERVERS)) DUT (
        .clk(clk), .rst_n(rst_n), .in(in), .in_valid(in_valid), .in_stall(in_stall),
        .out(out), .out_valid(out_valid), .out_stall(out_stall)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(out);
        out_stall <= (!quiet && $urandom_range(0, 99) < 26);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_word(in_word_t w);
        int gap;
        in       <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note(w);
        if (!quiet && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_item(func_t f, bit [3:0] id, bit [31:0] ip, bit [15:0] port,
                             bit [31:0] key);
        in_word_t w;
        w.func        = f;
        w.server_id   = id;
        w.server_ip   = ip;
        w.server_port = port;
        w.key_hash    = key;
        send_word(w);
    endtask

    initial
    begin
        in_word_t w;
        int       pick;
        sb          = new();
        quiet       = 1'b0;
        rst_n       = 1'b0;
        in          = '0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        idle_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(FUNC_LOOKUP, 4'd3, 32'd0, 16'd0, 32'h1234_5678);
        send_item(FUNC_NONE, 4'hf, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
        send_item(FUNC_CLEAR, 4'd0, 32'd0, 16'd0, 32'd0);
        send_item(FUNC_ADD, 4'd0, 32'd0, 16'd0, 32'd0);
        send_item(FUNC_ADD, 4'hf, 32'hffff_ffff, 16'hffff, 32'd0);
        send_item(FUNC_ADD, 4'hf, 32'hffff_ffff, 16'hffff, 32'd0);
        send_item(FUNC_ADD, 4'h9, 32'hc0a8_0001, 16'd80, 32'd0);
        send_item(FUNC_LOOKUP, 4'd0, 32'd0, 16'd0, 32'd0);
        send_item(FUNC_LOOKUP, 4'd0, 32'd0, 16'd0, 32'hffff_ffff);
        send_item(FUNC_LOOKUP, 4'd0, 32'd0, 16'd0, sb.point_hash[5]);
        send_item(FUNC_LOOKUP, 4'd0, 32'd0, 16'd0, sb.point_hash[5] - 32'd1);
        send_item(FUNC_LOOKUP, 4'd0, 32'd0, 16'd0, sb.point_hash[sb.point_total-1]);
        send_item(FUNC_CLEAR, 4'd0, 32'd0, 16'd0, 32'd0);
        for (int s = 0; s < MAX_SERVERS + 1; s++)
            send_item(FUNC_ADD, s[3:0], $urandom, 16'($urandom_range(0, 65535)), 32'd0);
        send_item(FUNC_LOOKUP, 4'd0, 32'd0, 16'd0, $urandom);
        send_item(FUNC_CLEAR, 4'd0, 32'd0, 16'd0, 32'd0);
        send_item(FUNC_LOOKUP, 4'd0, 32'd0, 16'd0, $urandom);

        for (int n = 0; n < 750; n++)
        begin
            quiet = (n >= 250 && n < 400);
            w.server_id   = 4'($urandom);
            w.server_ip   = $urandom;
            w.server_port = 16'($urandom);
            w.key_hash    = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 12)
                w.func = FUNC_CLEAR;
            else if (pick < 32)
                w.func = FUNC_ADD;
            else if (pick < 95)
                w.func = FUNC_LOOKUP;
            else
                w.func = FUNC_NONE;
            if (w.func == FUNC_LOOKUP && sb.point_total > 0 && $urandom_range(0, 3) == 0)
                w.key_hash = sb.point_hash[$urandom_range(0, sb.point_total - 1)];
            send_word(w);
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (sb.expected_q.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
